### hdl/fhbs_pkg.sv
// ----------------------------------------------------------------------------
// fhbs_pkg
// Shared types, constants and the FNV-1a byte step for the frame hash and
// bounding box statistics block.
// ----------------------------------------------------------------------------
package fhbs_pkg;

  // Default for the largest frame dimension.
  localparam int MaxDimensionDefault = 4096;

  // Widths fixed by the word layout.
  localparam int PixelBytes = 3;
  localparam int ByteW      = 8;
  localparam int CfgDataW   = 13;
  localparam int HashW      = 64;
  localparam int CountW     = 25;
  localparam int AccumW     = 37;
  localparam int SumW       = 36;
  localparam int BoxW       = 12;
  localparam int InDataW    = PixelBytes * ByteW;
  localparam int OutFieldsW = HashW + CountW + 2 * SumW + 4 * BoxW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Reset size registers.
  localparam logic [CfgDataW-1:0] WidthReset  = 13'd640;
  localparam logic [CfgDataW-1:0] HeightReset = 13'd480;

  // FNV-1a 64: prime = 2^40 + 0x1b3.
  localparam logic [HashW-1:0] FnvBasis = 64'hcbf2_9ce4_8422_2325;

  // Byte counter of the hash sequencer.
  localparam logic [1:0] FirstByte = 2'd0;
  localparam logic [1:0] LastByte  = 2'd2;

  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    StIdle = 1'b0,
    StHash = 1'b1
  } seq_state_e;

  // One FNV-1a step: xor the byte in, multiply by the prime (mod 2^64).
  // The prime times x is x<<40 plus x*435, and 435 = 256+128+32+16+2+1.
  function automatic logic [HashW-1:0] fnv_step(input logic [HashW-1:0] h,
                                                input logic [ByteW-1:0] b);
    logic [HashW-1:0] x;
    x = h ^ {{(HashW-ByteW){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

### hdl/frame_fnv_hash_and_bbox_stats.sv
// ----------------------------------------------------------------------------
// frame_fnv_hash_and_bbox_stats
// Folds an FNV-1a 64 hash over every pixel byte of a raster frame and keeps
// count, coordinate sums and the bounding box of the non-black pixels.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                     | word
//  ----------+-----+-------------------------------+------------------------------
//  s_axis    | in  | s_axis_tvalid_i/_tready_o     | one pixel, three bytes
//  m_axis    | out | m_axis_tvalid_o/_tready_i     | frame result, once per frame
//  cfg       | in  | cfg_valid_i/cfg_ready_o       | frame width / height write
//
//  One shared FNV byte step (xor + multiply by the prime) runs once per
//  pixel byte, in byte order. Position and statistics update in the accept
//  cycle; a new pixel is taken in the cycle of the previous one's last step.
//  The final pixel's last step waits while a previous result is still held.
//  Reset loads sizes 640 x 480 and clears all frame state.
//
module frame_fnv_hash_and_bbox_stats #(
  parameter int MaxDimension = fhbs_pkg::MaxDimensionDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [7:0] byte_first, [15:8] byte_second, [23:16] byte_third
  input  logic [fhbs_pkg::InDataW-1:0]   s_axis_tdata_i,
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [63:0] frame_hash, [88:64] lit_count, [124:89] column_sum,
  // [160:125] row_sum, [172:161] box_left, [184:173] box_top,
  // [196:185] box_right, [208:197] box_bottom, [215:209] zero
  output logic [fhbs_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [0] any_lit
  output logic                           m_axis_tuser_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  fhbs_pkg::cfg_reg_e             cfg_index_i,
  input  logic [fhbs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fhbs_pkg::*;

  localparam int SizeW = $clog2(MaxDimension + 1);
  localparam int PosW1 = SizeW + 1;
  localparam int CmpW  = (PosW1 > CfgDataW) ? PosW1 : CfgDataW;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [CfgDataW-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFrameWidth:  width_q  <= cfg_data_i;
        CfgFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, above the limit acts as the limit
  logic [CmpW-1:0]  width_x, height_x;
  logic [PosW1-1:0] w_eff, h_eff;

  always_comb begin
    width_x  = CmpW'(width_q);
    height_x = CmpW'(height_q);
    if (width_x == '0)                        w_eff = PosW1'(1);
    else if (width_x > CmpW'(MaxDimension))   w_eff = PosW1'(MaxDimension);
    else                                      w_eff = PosW1'(width_x);
    if (height_x == '0)                       h_eff = PosW1'(1);
    else if (height_x > CmpW'(MaxDimension))  h_eff = PosW1'(MaxDimension);
    else                                      h_eff = PosW1'(height_x);
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  seq_state_e state_q, state_d;
  logic [1:0] byte_idx_q, byte_idx_d;
  logic       last_q, last_d;
  logic       out_valid_q;
  logic       out_free, step_en, emit, accept;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;

  // outputs of the sequencer
  always_comb begin
    step_en = 1'b0;
    emit    = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_axis_tready_o = 1'b1;
      end
      StHash: begin
        step_en         = !(byte_idx_q == LastByte && last_q && !out_free);
        emit            = (byte_idx_q == LastByte) && last_q && out_free;
        s_axis_tready_o = (byte_idx_q == LastByte) && step_en;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d    = state_q;
    byte_idx_d = byte_idx_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d    = StHash;
          byte_idx_d = FirstByte;
        end
      end
      StHash: begin
        if (accept) begin
          byte_idx_d = FirstByte;
        end else if (step_en) begin
          if (byte_idx_q == LastByte) state_d = StIdle;
          else                        byte_idx_d = byte_idx_q + 2'd1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      byte_idx_q <= FirstByte;
    end else begin
      state_q    <= state_d;
      byte_idx_q <= byte_idx_d;
    end
  end

  // --------------------------------------------------------------------------
  // shared hash step
  // --------------------------------------------------------------------------
  logic [InDataW-1:0] pixel_q;
  logic [HashW-1:0]   hash_q, hash_d, hash_step;
  logic [ByteW-1:0]   byte_sel;

  always_comb begin
    case (byte_idx_q)
      FirstByte: byte_sel = pixel_q[ByteW-1:0];
      2'd1:      byte_sel = pixel_q[2*ByteW-1:ByteW];
      default:   byte_sel = pixel_q[3*ByteW-1:2*ByteW];
    endcase
  end

  assign hash_step = fnv_step(hash_q, byte_sel);

  always_comb begin
    hash_d = hash_q;
    if (emit)         hash_d = FnvBasis;
    else if (step_en) hash_d = hash_step;
  end

  always_ff @(posedge clk_i) begin
    if (accept) pixel_q <= s_axis_tdata_i;
  end

  // --------------------------------------------------------------------------
  // position and statistics, updated in the accept cycle
  // --------------------------------------------------------------------------
  logic [SizeW-1:0]  col_q, col_d, row_q, row_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [AccumW-1:0] col_acc_q, col_acc_d, row_acc_q, row_acc_d;
  logic [SizeW-1:0]  min_col_q, min_col_d, min_row_q, min_row_d;
  logic [SizeW-1:0]  max_col_q, max_col_d, max_row_q, max_row_d;
  logic              seen_q, seen_d;

  logic [PosW1-1:0]  col_start, row_start, col_inc, row_inc;
  logic              lit, wrap;

  assign lit = |s_axis_tdata_i;

  always_comb begin
    // start from cleared state when the frame ends in this same cycle
    if (emit) begin
      col_d     = '0;
      row_d     = '0;
      cnt_d     = '0;
      col_acc_d = '0;
      row_acc_d = '0;
      min_col_d = '1;
      min_row_d = '1;
      max_col_d = '0;
      max_row_d = '0;
      seen_d    = 1'b0;
    end else begin
      col_d     = col_q;
      row_d     = row_q;
      cnt_d     = cnt_q;
      col_acc_d = col_acc_q;
      row_acc_d = row_acc_q;
      min_col_d = min_col_q;
      min_row_d = min_row_q;
      max_col_d = max_col_q;
      max_row_d = max_row_q;
      seen_d    = seen_q;
    end
    last_d = last_q;

    // a column left past a shrunk width wraps to the next row
    wrap      = PosW1'(col_d) >= w_eff;
    col_start = wrap ? '0 : PosW1'(col_d);
    row_start = wrap ? PosW1'(row_d) + PosW1'(1) : PosW1'(row_d);
    col_inc   = col_start + PosW1'(1);
    row_inc   = row_start + PosW1'(1);

    if (accept) begin
      last_d = (col_inc >= w_eff) && (row_inc >= h_eff);
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = SizeW'(row_inc);
      end else begin
        col_d = SizeW'(col_inc);
        row_d = SizeW'(row_start);
      end
      if (lit) begin
        cnt_d     = cnt_d + CountW'(1);
        col_acc_d = col_acc_d + AccumW'(col_start);
        row_acc_d = row_acc_d + AccumW'(row_start);
        if (!seen_d || SizeW'(col_start) < min_col_d) min_col_d = SizeW'(col_start);
        if (!seen_d || SizeW'(row_start) < min_row_d) min_row_d = SizeW'(row_start);
        if (!seen_d || SizeW'(col_start) > max_col_d) max_col_d = SizeW'(col_start);
        if (!seen_d || SizeW'(row_start) > max_row_d) max_row_d = SizeW'(row_start);
        seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= FnvBasis;
      col_q     <= '0;
      row_q     <= '0;
      cnt_q     <= '0;
      col_acc_q <= '0;
      row_acc_q <= '0;
      min_col_q <= '1;
      min_row_q <= '1;
      max_col_q <= '0;
      max_row_q <= '0;
      seen_q    <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      hash_q    <= hash_d;
      col_q     <= col_d;
      row_q     <= row_d;
      cnt_q     <= cnt_d;
      col_acc_q <= col_acc_d;
      row_acc_q <= row_acc_d;
      min_col_q <= min_col_d;
      min_row_q <= min_row_d;
      max_col_q <= max_col_d;
      max_row_q <= max_row_d;
      seen_q    <= seen_d;
      last_q    <= last_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic [OutDataW-1:0] out_data_q;
  logic                out_lit_q;
  logic [BoxW-1:0]     box_left, box_top, box_right, box_bottom;

  assign box_left   = seen_q ? BoxW'(min_col_q) : '0;
  assign box_top    = seen_q ? BoxW'(min_row_q) : '0;
  assign box_right  = seen_q ? BoxW'(max_col_q) : '0;
  assign box_bottom = seen_q ? BoxW'(max_row_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= OutDataW'({box_bottom, box_right, box_top, box_left,
                               row_acc_q[SumW-1:0], col_acc_q[SumW-1:0],
                               cnt_q, hash_step});
      out_lit_q  <= seen_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_lit_q;

endmodule

### dv/frame_fnv_hash_and_bbox_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_fnv_hash_and_bbox_stats_checker
// Passive monitor for the frame hash / bounding box block. Tracks config
// writes and accepted pixels, predicts each frame result on the fly and
// compares it field by field with the words leaving the result stream.
// ----------------------------------------------------------------------------
module frame_fnv_hash_and_bbox_stats_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  // [7:0] byte_first, [15:8] byte_second, [23:16] byte_third
  input  logic [fhbs_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  // [63:0] frame_hash, [88:64] lit_count, [124:89] column_sum,
  // [160:125] row_sum, [172:161] box_left, [184:173] box_top,
  // [196:185] box_right, [208:197] box_bottom, [215:209] zero
  input  logic [fhbs_pkg::OutDataW-1:0]  m_axis_tdata_i,
  // [0] any_lit
  input  logic                           m_axis_tuser_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  fhbs_pkg::cfg_reg_e             cfg_index_i,
  input  logic [fhbs_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                             failures_o,
  output int                             pending_o,
  output int                             pixels_o,
  output int                             frames_o
);
  import fhbs_pkg::*;

  localparam logic [HashW-1:0] FnvOffset = 64'hcbf2_9ce4_8422_2325;
  localparam logic [HashW-1:0] FnvPrime  = 64'h0000_0100_0000_01b3;
  localparam int               MaxShown  = 10;

  // Same bit order as {tuser, tdata[208:0]}.
  typedef struct packed {
    logic              any_lit;
    logic [BoxW-1:0]   box_bottom;
    logic [BoxW-1:0]   box_right;
    logic [BoxW-1:0]   box_top;
    logic [BoxW-1:0]   box_left;
    logic [SumW-1:0]   row_sum;
    logic [SumW-1:0]   column_sum;
    logic [CountW-1:0] lit_count;
    logic [HashW-1:0]  frame_hash;
  } frame_report_t;

  frame_report_t frame_reports_q[$];

  logic [CfgDataW-1:0] width_setting;
  logic [CfgDataW-1:0] height_setting;

  logic [HashW-1:0]    hash_acc;
  logic [CountW-1:0]   lit_cnt;
  logic [AccumW-1:0]   col_acc;
  logic [AccumW-1:0]   row_acc;
  logic [BoxW-1:0]     min_col;
  logic [BoxW-1:0]     min_row;
  logic [BoxW-1:0]     max_col;
  logic [BoxW-1:0]     max_row;
  bit                  lit_seen;
  int unsigned         col_pos;
  int unsigned         row_pos;

  function automatic logic [HashW-1:0] fnv_mix(logic [HashW-1:0] h, logic [ByteW-1:0] b);
    return (h ^ {{(HashW-ByteW){1'b0}}, b}) * FnvPrime;
  endfunction

  // zero acts as one, anything past the maximum is clamped
  function automatic int unsigned clamp_size(logic [CfgDataW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxDimensionDefault) return MaxDimensionDefault;
    return v;
  endfunction

  function void restart_frame();
    hash_acc = FnvOffset;
    lit_cnt  = '0;
    col_acc  = '0;
    row_acc  = '0;
    min_col  = '1;
    min_row  = '1;
    max_col  = '0;
    max_row  = '0;
    lit_seen = 1'b0;
    col_pos  = 0;
    row_pos  = 0;
  endfunction

  function automatic string describe(frame_report_t r);
    return $sformatf("hash=%h count=%0d csum=%0d rsum=%0d box=(%0d,%0d)-(%0d,%0d) lit=%0b",
                     r.frame_hash, r.lit_count, r.column_sum, r.row_sum,
                     r.box_left, r.box_top, r.box_right, r.box_bottom, r.any_lit);
  endfunction

  task automatic fold_pixel(input logic [InDataW-1:0] px, output bit frame_done,
                            output frame_report_t rep);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    w = clamp_size(width_setting);
    h = clamp_size(height_setting);
    rep = '0;
    // a size shrunk mid-frame wraps the column here
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    col = col_pos;
    row = row_pos;
    hash_acc = fnv_mix(hash_acc, px[7:0]);
    hash_acc = fnv_mix(hash_acc, px[15:8]);
    hash_acc = fnv_mix(hash_acc, px[23:16]);
    if (px != '0) begin
      lit_cnt = lit_cnt + 1'b1;
      col_acc = col_acc + col;
      row_acc = row_acc + row;
      if (!lit_seen || col < min_col) min_col = col[BoxW-1:0];
      if (!lit_seen || row < min_row) min_row = row[BoxW-1:0];
      if (!lit_seen || col > max_col) max_col = col[BoxW-1:0];
      if (!lit_seen || row > max_row) max_row = row[BoxW-1:0];
      lit_seen = 1'b1;
    end
    frame_done = (col + 1 >= w) && (row + 1 >= h);
    if (!frame_done) begin
      col_pos = col + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = row + 1;
      end
    end else begin
      rep.frame_hash = hash_acc;
      rep.lit_count  = lit_cnt;
      rep.column_sum = col_acc[SumW-1:0];
      rep.row_sum    = row_acc[SumW-1:0];
      if (lit_seen) begin
        rep.box_left   = min_col;
        rep.box_top    = min_row;
        rep.box_right  = max_col;
        rep.box_bottom = max_row;
        rep.any_lit    = 1'b1;
      end
      restart_frame();
    end
  endtask

  always @(posedge clk_i) begin
    frame_report_t got;
    frame_report_t want;
    frame_report_t fresh;
    bit            done;
    if (!rst_ni) begin
      width_setting  = WidthReset;
      height_setting = HeightReset;
      restart_frame();
      frame_reports_q.delete();
      failures_o = 0;
      pending_o  = 0;
      pixels_o   = 0;
      frames_o   = 0;
    end else begin
      // retire first: a word leaving now never belongs to a pixel taken now
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = frame_report_t'({m_axis_tuser_i, m_axis_tdata_i[OutFieldsW-1:0]});
        if (frame_reports_q.size() == 0) begin
          if (failures_o < MaxShown)
            $display("[%0t] unexpected result word: %s", $time, describe(got));
          failures_o++;
        end else begin
          want = frame_reports_q.pop_front();
          if (got !== want) begin
            if (failures_o < MaxShown) begin
              $display("[%0t] frame %0d mismatch", $time, frames_o);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
            failures_o++;
          end
        end
        frames_o++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgFrameWidth) width_setting = cfg_data_i;
        else height_setting = cfg_data_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        fold_pixel(s_axis_tdata_i, done, fresh);
        if (done) frame_reports_q.push_back(fresh);
        pixels_o++;
      end
      pending_o = frame_reports_q.size();
    end
  end

endmodule

### dv/frame_fnv_hash_and_bbox_stats_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_fnv_hash_and_bbox_stats_tb
// Drives pixel frames and size writes into the block: corner pixels, clamped
// and mid-frame-changed sizes, a long output hold and random frames under
// several idle mixes. A checker scores the results.
// ----------------------------------------------------------------------------
module frame_fnv_hash_and_bbox_stats_tb;
  import fhbs_pkg::*;

  localparam int CycleLimit  = 1_000_000;
  localparam int HoldCycles  = 400;
  localparam int RandomItems = 820;
  localparam int DrainCycles = 8;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata   = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  cfg_reg_e            cfg_index      = CfgFrameWidth;
  logic [CfgDataW-1:0] cfg_data       = '0;

  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int          hold_req       = 0;
  int          failures;
  int          pending;
  int          pixels;
  int          frames;
  int unsigned cycle_cnt      = 0;

  always #2 clk_i = ~clk_i;

  frame_fnv_hash_and_bbox_stats DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  frame_fnv_hash_and_bbox_stats_checker frame_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .failures_o      (failures),
    .pending_o       (pending),
    .pixels_o        (pixels),
    .frames_o        (frames)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("** frame_fnv_hash_and_bbox_stats: FAILED **");
      $finish;
    end
  end

  // result sink: random stalls, plus a long hold whenever one is requested
  initial begin : sink
    int hold_taken;
    int hold_left;
    hold_taken = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_taken) begin
        hold_taken = hold_req;
        hold_left  = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // all tasks start and end on a falling edge
  task automatic send_pixel(input logic [InDataW-1:0] px);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [InDataW-1:0] random_pixel();
    logic [InDataW-1:0] one_byte;
    case ($urandom_range(9))
      0, 1, 2, 3: return '0;
      4, 5: begin
        one_byte = {16'd0, 8'($urandom_range(255, 1))};
        return one_byte << (8 * $urandom_range(2));
      end
      default: return InDataW'($urandom);
    endcase
  endfunction

  task automatic send_batch(input int n);
    repeat (n) send_pixel(random_pixel());
  endtask

  // stop offering, let every predicted word drain, then allow the last
  // pixel's byte steps to finish in case it ended no frame
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_sizes(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CfgFrameWidth;
    cfg_data  <= w;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_index <= CfgFrameHeight;
    cfg_data  <= h;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_size();
    return ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 7);
  endfunction

  initial begin
    int w;
    int h;
    int area;
    int n;
    int sent;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-pixel frames via zero sizes: black, white, lowest and highest bit
    write_sizes(0, 0);
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'h000001);
    send_pixel(24'h800000);

    // 3x2 with two lit pixels, box spans (1,0)-(2,1)
    settle();
    write_sizes(3, 2);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
    send_pixel(24'h000100);
    send_pixel(24'h000000);
    send_pixel(24'h010000);
    send_pixel(24'h000000);

    // width shrinks below the current column mid-frame
    settle();
    write_sizes(4, 3);
    send_batch(6);
    settle();
    write_sizes(2, 3);
    send_batch(2);

    // height shrinks below the current row mid-frame
    settle();
    write_sizes(3, 3);
    send_batch(4);
    settle();
    write_sizes(3, 1);
    send_batch(2);

    // receiver holds off long enough for the block to back up its input
    settle();
    write_sizes(1, 1);
    hold_req = hold_req + 1;
    send_batch(40);

    // oversized sizes clamp to the limit; the frame then ends on a resize
    settle();
    write_sizes(13'h1fff, 13'h1fff);
    send_batch(5);
    settle();
    write_sizes(2, 0);
    send_batch(2);

    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
        default: begin src_idle_pct = 12; sink_stall_pct = 12; end
      endcase
      sent = 0;
      while (sent < RandomItems / 4) begin
        w = pick_size();
        h = pick_size();
        settle();
        write_sizes(CfgDataW'(w), CfgDataW'(h));
        area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
        // mostly whole frames; some batches stop mid-frame before a resize
        if ($urandom_range(4) == 0) n = $urandom_range(2 * area, 1);
        else n = area * $urandom_range(3, 1);
        send_batch(n);
        sent += n;
      end
    end

    settle();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d pixels and %0d frame results: corner pixels, clamped and", pixels,
             frames);
    $display("mid-frame resizes, a long output hold and four sender/receiver idle mixes.");
    if (failures == 0) begin
      $display("** frame_fnv_hash_and_bbox_stats: PASSED **");
    end else begin
      $display("** frame_fnv_hash_and_bbox_stats: FAILED **");
    end
    $finish;
  end

endmodule
